// File: hdl/qrs_pkg.sv
// Shared widths, status codes and the queue item type of the quadratic root solver.
// No dependencies; every other file uses it by scoped names.
`timescale 1ns / 1ps

package qrs_pkg;

	localparam int COEF_WIDTH = 16;
	localparam int FRAC_BITS  = 16;
	localparam int ROOT_W     = 33;

	// b*b + 4|a*c| stays below 2^(2*COEF_WIDTH+1)
	localparam int DISC_W  = 2 * COEF_WIDTH + 1;
	localparam int SQ_W    = COEF_WIDTH + FRAC_BITS + 1;
	localparam int RAD_W   = 2 * SQ_W;
	localparam int SQR_W   = SQ_W + 3;
	localparam int BASE_W  = COEF_WIDTH + FRAC_BITS + 1;
	localparam int DEN_SW  = COEF_WIDTH + 1;
	localparam int DEN_W   = COEF_WIDTH + 1;
	localparam int NUM_W   = COEF_WIDTH + FRAC_BITS + 2;
	localparam int NUM_SW  = NUM_W + 1;
	localparam int DVR_W   = DEN_W + 1;
	localparam int CMP_W   = NUM_W + ROOT_W;

	localparam int QDEPTH  = 4;
	localparam int QA_W    = $clog2(QDEPTH);
	localparam int QC_W    = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		ST_INVALID = 2'd0,
		ST_IMAG    = 2'd1,
		ST_LINEAR  = 2'd2,
		ST_TWO     = 2'd3
	} qrs_status_t;

	typedef struct packed {
		qrs_status_t                status;
		logic        [DISC_W-1:0]   disc;
		logic signed [BASE_W-1:0]   base;
		logic signed [DEN_SW-1:0]   den;
	} qrs_item_t;

	typedef struct packed {
		qrs_status_t                status;
		logic                       neg1;
		logic                       neg2;
		logic        [DEN_W-1:0]    dmag;
	} qrs_div_ctl_t;

endpackage

// File: hdl/qrs_coef_if.sv
// Input channel of the quadratic root solver: one set of coefficients per request.
// Depends on qrs_pkg for the coefficient width.
`timescale 1ns / 1ps

interface qrs_coef_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [qrs_pkg::COEF_WIDTH-1:0]    coef_a;
	logic signed [qrs_pkg::COEF_WIDTH-1:0]    coef_b;
	logic signed [qrs_pkg::COEF_WIDTH-1:0]    coef_c;

	modport source (output valid, coef_a, coef_b, coef_c, input ready);
	modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

// File: hdl/qrs_root_if.sv
// Output channel of the quadratic root solver: status and two Q17.16 roots per request.
// Depends on qrs_pkg for the root width.
`timescale 1ns / 1ps

interface qrs_root_if;
	logic                                 valid;
	logic                                 ready;
	logic        [1:0]                    root_status;
	logic signed [qrs_pkg::ROOT_W-1:0]    root_first;
	logic signed [qrs_pkg::ROOT_W-1:0]    root_second;

	modport source (output valid, root_status, root_first, root_second, input ready);
	modport sink   (input valid, root_status, root_first, root_second, output ready);
endinterface

// File: hdl/quadratic_root_solver.sv
// Quadratic root solver: real roots of a*x*x + b*x + c = 0 in signed Q17.16.
// Uses qrs_pkg, qrs_coef_if, qrs_root_if, qrs_front, qrs_queue, qrs_sqrt and qrs_div.
//
// Accepts one set of coefficients per clock unless the queue is full, and returns
// one result per request, in order. A request passes the front stages s1 and s2,
// the queue and its head register, 33 square root stages (one root bit each), 34
// divider stages (one quotient bit each) and one saturation/result register. A stall on
// the result side halts the root and divide pipeline; the queue (four entries plus its output
// register) lets the front end keep taking coefficients until it fills. No reset
// pass is needed.
`timescale 1ns / 1ps

module quadratic_root_solver (
	input  logic       clk,
	input  logic       arst_n,
	qrs_coef_if.sink   coef,
	qrs_root_if.source root
);
	logic                              push, pop, q_full, q_empty, en;
	qrs_pkg::qrs_item_t                push_item, pop_item, sq_item;
	logic                              sq_valid;
	logic [qrs_pkg::SQ_W-1:0]          sq_root;
	qrs_pkg::qrs_status_t              status;

	// advance the back end whenever the result register is free
	assign en  = !root.valid || root.ready;
	assign pop = en && !q_empty;

	qrs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	qrs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	qrs_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pop),
		.in_item   (pop_item),
		.out_valid (sq_valid),
		.out_item  (sq_item),
		.out_root  (sq_root)
	);

	qrs_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (sq_valid),
		.in_item    (sq_item),
		.in_root    (sq_root),
		.out_valid  (root.valid),
		.out_status (status),
		.out_first  (root.root_first),
		.out_second (root.root_second)
	);

	assign root.root_status = status;

endmodule

// File: hdl/qrs_front.sv
// Front end: takes coefficients, forms the exact discriminant and classifies the equation.
// Depends on qrs_pkg and qrs_coef_if; pushes one qrs_item_t per request into the queue.
`timescale 1ns / 1ps

module qrs_front (
	input  logic               clk,
	input  logic               arst_n,
	qrs_coef_if.sink           coef,
	input  logic               q_full,
	output logic               push,
	output qrs_pkg::qrs_item_t push_item
);
	localparam int CW = qrs_pkg::COEF_WIDTH;

	logic                  v_s1, v_s2;
	logic                  adv;
	logic signed [CW-1:0]  a_s1, b_s1, c_s1;
	logic [2*CW-1:0]       bb_s1, ac_s1;
	logic                  acneg_s1;
	logic [CW-1:0]         am, bm, cm;
	qrs_pkg::qrs_item_t    item_d, item_s2;
	logic [qrs_pkg::DISC_W-1:0] bb_x, ac4_x;
	logic signed [qrs_pkg::BASE_W-1:0] bx, cx;
	logic signed [qrs_pkg::DEN_SW-1:0] ax, bdx;

	// hold both stages while stage 2 holds an item and the queue is full
	assign adv        = !v_s2 || !q_full;
	assign coef.ready = adv;
	assign push       = v_s2 && !q_full;
	assign push_item  = item_s2;

	always_comb begin
		am = coef.coef_a[CW-1] ? CW'(-coef.coef_a) : CW'(coef.coef_a);
		bm = coef.coef_b[CW-1] ? CW'(-coef.coef_b) : CW'(coef.coef_b);
		cm = coef.coef_c[CW-1] ? CW'(-coef.coef_c) : CW'(coef.coef_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= coef.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1     <= coef.coef_a;
			b_s1     <= coef.coef_b;
			c_s1     <= coef.coef_c;
			bb_s1    <= bm * bm;
			ac_s1    <= am * cm;
			acneg_s1 <= coef.coef_a[CW-1] ^ coef.coef_c[CW-1];
			item_s2  <= item_d;
		end
	end

	always_comb begin
		bb_x  = qrs_pkg::DISC_W'(bb_s1);
		ac4_x = qrs_pkg::DISC_W'({ac_s1, 2'b00});
		bx    = qrs_pkg::BASE_W'(b_s1);
		cx    = qrs_pkg::BASE_W'(c_s1);
		ax    = qrs_pkg::DEN_SW'(a_s1);
		bdx   = qrs_pkg::DEN_SW'(b_s1);
		item_d.disc = '0;
		item_d.base = (-bx) <<< qrs_pkg::FRAC_BITS;
		item_d.den  = ax <<< 1;
		if (a_s1 == '0 && b_s1 == '0) begin
			item_d.status = qrs_pkg::ST_INVALID;
		end else if (a_s1 == '0) begin
			item_d.status = qrs_pkg::ST_LINEAR;
			item_d.base   = (-cx) <<< qrs_pkg::FRAC_BITS;
			item_d.den    = bdx;
		end else if (acneg_s1 || ac4_x == '0) begin
			item_d.status = qrs_pkg::ST_TWO;
			item_d.disc   = bb_x + ac4_x;
		end else if (bb_x >= ac4_x) begin
			item_d.status = qrs_pkg::ST_TWO;
			item_d.disc   = bb_x - ac4_x;
		end else begin
			item_d.status = qrs_pkg::ST_IMAG;
		end
	end

endmodule

// File: hdl/qrs_queue.sv
// Short queue between the front end and the root pipeline.
// Depends on qrs_pkg for the item type and depth.
`timescale 1ns / 1ps

module qrs_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  qrs_pkg::qrs_item_t push_item,
	input  logic               pop,
	output qrs_pkg::qrs_item_t pop_item,
	output logic               full,
	output logic               empty
);
	qrs_pkg::qrs_item_t             mem [qrs_pkg::QDEPTH];
	logic [qrs_pkg::QA_W-1:0]       wr_q, rd_q;
	logic [qrs_pkg::QC_W-1:0]       cnt_q;
	qrs_pkg::qrs_item_t             head_q;
	logic                           hv_q;
	logic                           refill, wr_en, rd_en;

	// the head register is the read port; refill it when it drains
	assign refill   = pop || !hv_q;
	assign rd_en    = refill && cnt_q != '0;
	assign wr_en    = push && !(refill && cnt_q == '0);

	assign full     = cnt_q == qrs_pkg::QC_W'(qrs_pkg::QDEPTH);
	assign empty    = !hv_q;
	assign pop_item = head_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_q] <= push_item;
		end
		if (rd_en) begin
			head_q <= mem[rd_q];
		end else if (refill && push) begin
			head_q <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
			hv_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				wr_q <= wr_q + 1'b1;
			end
			if (rd_en) begin
				rd_q <= rd_q + 1'b1;
			end
			if (refill) begin
				hv_q <= (cnt_q != '0) || push;
			end
			cnt_q <= cnt_q + qrs_pkg::QC_W'(wr_en) - qrs_pkg::QC_W'(rd_en);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("queue pop while empty");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q == $past(cnt_q) + qrs_pkg::QC_W'($past(wr_en))
			- qrs_pkg::QC_W'($past(rd_en))) else $error("queue count mismatch");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= qrs_pkg::QC_W'(qrs_pkg::QDEPTH)) else $error("queue count out of range");
	a_head_first: assert property (@(posedge clk) disable iff (!arst_n)
		!hv_q |-> cnt_q == '0) else $error("queue entries behind an empty head");

endmodule

// File: hdl/qrs_sqrt.sv
// Pipelined floor square root of disc * 2^(2*FRAC_BITS), one root bit per stage.
// Depends on qrs_pkg; carries the queue item alongside the root.
`timescale 1ns / 1ps

module qrs_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  qrs_pkg::qrs_item_t        in_item,
	output logic                      out_valid,
	output qrs_pkg::qrs_item_t        out_item,
	output logic [qrs_pkg::SQ_W-1:0]  out_root
);
	localparam int N = qrs_pkg::SQ_W;

	logic                         v_s    [N];
	qrs_pkg::qrs_item_t           item_s [N];
	logic [qrs_pkg::SQR_W-1:0]    rem_s  [N];
	logic [N-1:0]                 root_s [N];
	logic [qrs_pkg::RAD_W-1:0]    rad_s  [N];

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_stage
			logic                         pv;
			qrs_pkg::qrs_item_t           pitem;
			logic [qrs_pkg::SQR_W-1:0]    prem, rsh, trial;
			logic [N-1:0]                 proot;
			logic [qrs_pkg::RAD_W-1:0]    prad;
			logic                         ge;

			if (k == 0) begin : g_in
				assign pv    = in_valid;
				assign pitem = in_item;
				assign prem  = '0;
				assign proot = '0;
				assign prad  = qrs_pkg::RAD_W'({in_item.disc,
					{(2 * qrs_pkg::FRAC_BITS){1'b0}}});
			end else begin : g_mid
				assign pv    = v_s[k-1];
				assign pitem = item_s[k-1];
				assign prem  = rem_s[k-1];
				assign proot = root_s[k-1];
				assign prad  = rad_s[k-1];
			end

			// bring down the next bit pair and try 4*root+1
			assign rsh   = {prem[qrs_pkg::SQR_W-3:0], prad[qrs_pkg::RAD_W-1 -: 2]};
			assign trial = {1'b0, proot, 2'b01};
			assign ge    = rsh >= trial;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en) begin
					v_s[k] <= pv;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					item_s[k] <= pitem;
					rem_s[k]  <= ge ? rsh - trial : rsh;
					root_s[k] <= {proot[N-2:0], ge};
					rad_s[k]  <= prad << 2;
				end
			end
		end
	endgenerate

	assign out_valid = v_s[N-1];
	assign out_item  = item_s[N-1];
	assign out_root  = root_s[N-1];

endmodule

// File: hdl/qrs_div.sv
// Two pipelined restoring dividers (one quotient bit per stage), then saturation.
// Depends on qrs_pkg; its last stage is the result register of the block.
`timescale 1ns / 1ps

module qrs_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  qrs_pkg::qrs_item_t                in_item,
	input  logic [qrs_pkg::SQ_W-1:0]          in_root,
	output logic                              out_valid,
	output qrs_pkg::qrs_status_t              out_status,
	output logic signed [qrs_pkg::ROOT_W-1:0] out_first,
	output logic signed [qrs_pkg::ROOT_W-1:0] out_second
);
	localparam int N = qrs_pkg::NUM_W;

	logic signed [qrs_pkg::NUM_SW-1:0] sx, num1, num2, basex;
	logic [N-1:0]                      mag1, mag2;
	qrs_pkg::qrs_div_ctl_t             ctl_in;

	logic                         v_s    [N];
	qrs_pkg::qrs_div_ctl_t        ctl_s  [N];
	logic [qrs_pkg::DVR_W-1:0]    r1_s   [N];
	logic [qrs_pkg::DVR_W-1:0]    r2_s   [N];
	logic [N-1:0]                 n1_s   [N];
	logic [N-1:0]                 n2_s   [N];
	logic [N-1:0]                 q1_s   [N];
	logic [N-1:0]                 q2_s   [N];

	logic                              v_q;
	qrs_pkg::qrs_status_t              st_q;
	logic signed [qrs_pkg::ROOT_W-1:0] first_q, second_q;

	always_comb begin
		basex = qrs_pkg::NUM_SW'(in_item.base);
		sx    = (in_item.status == qrs_pkg::ST_TWO) ? qrs_pkg::NUM_SW'(in_root) : '0;
		num1  = basex + sx;
		num2  = basex - sx;
		mag1  = num1[qrs_pkg::NUM_SW-1] ? N'(-num1) : N'(num1);
		mag2  = num2[qrs_pkg::NUM_SW-1] ? N'(-num2) : N'(num2);
		ctl_in.status = in_item.status;
		ctl_in.neg1   = num1[qrs_pkg::NUM_SW-1] ^ in_item.den[qrs_pkg::DEN_SW-1];
		ctl_in.neg2   = num2[qrs_pkg::NUM_SW-1] ^ in_item.den[qrs_pkg::DEN_SW-1];
		ctl_in.dmag   = in_item.den[qrs_pkg::DEN_SW-1] ?
			qrs_pkg::DEN_W'(-in_item.den) : qrs_pkg::DEN_W'(in_item.den);
	end

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_stage
			logic                         pv;
			qrs_pkg::qrs_div_ctl_t        pctl;
			logic [qrs_pkg::DVR_W-1:0]    pr1, pr2, sh1, sh2, dx;
			logic [N-1:0]                 pn1, pn2, pq1, pq2;
			logic                         ge1, ge2;

			if (k == 0) begin : g_in
				assign pv   = in_valid;
				assign pctl = ctl_in;
				assign pr1  = '0;
				assign pr2  = '0;
				assign pn1  = mag1;
				assign pn2  = mag2;
				assign pq1  = '0;
				assign pq2  = '0;
			end else begin : g_mid
				assign pv   = v_s[k-1];
				assign pctl = ctl_s[k-1];
				assign pr1  = r1_s[k-1];
				assign pr2  = r2_s[k-1];
				assign pn1  = n1_s[k-1];
				assign pn2  = n2_s[k-1];
				assign pq1  = q1_s[k-1];
				assign pq2  = q2_s[k-1];
			end

			assign dx  = qrs_pkg::DVR_W'(pctl.dmag);
			assign sh1 = {pr1[qrs_pkg::DVR_W-2:0], pn1[N-1]};
			assign sh2 = {pr2[qrs_pkg::DVR_W-2:0], pn2[N-1]};
			assign ge1 = sh1 >= dx;
			assign ge2 = sh2 >= dx;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en) begin
					v_s[k] <= pv;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					ctl_s[k] <= pctl;
					r1_s[k]  <= ge1 ? sh1 - dx : sh1;
					r2_s[k]  <= ge2 ? sh2 - dx : sh2;
					n1_s[k]  <= pn1 << 1;
					n2_s[k]  <= pn2 << 1;
					q1_s[k]  <= {pq1[N-2:0], ge1};
					q2_s[k]  <= {pq2[N-2:0], ge2};
				end
			end
		end
	endgenerate

	function automatic logic signed [qrs_pkg::ROOT_W-1:0] sat_root(
		input logic [N-1:0] qmag,
		input logic         neg
	);
		logic [qrs_pkg::CMP_W-1:0]         qx, lim;
		logic signed [qrs_pkg::ROOT_W-1:0] r;
		qx  = qrs_pkg::CMP_W'(qmag);
		lim = qrs_pkg::CMP_W'(1) << (qrs_pkg::ROOT_W - 1);
		r   = qrs_pkg::ROOT_W'(qmag);
		if (!neg && qx >= lim) begin
			r = {1'b0, {(qrs_pkg::ROOT_W - 1){1'b1}}};
		end else if (neg && qx > lim) begin
			r = {1'b1, {(qrs_pkg::ROOT_W - 1){1'b0}}};
		end else if (neg) begin
			r = -r;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_s[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q     <= ctl_s[N-1].status;
			first_q  <= '0;
			second_q <= '0;
			if (ctl_s[N-1].status == qrs_pkg::ST_LINEAR ||
			    ctl_s[N-1].status == qrs_pkg::ST_TWO) begin
				first_q <= sat_root(q1_s[N-1], ctl_s[N-1].neg1);
			end
			if (ctl_s[N-1].status == qrs_pkg::ST_TWO) begin
				second_q <= sat_root(q2_s[N-1], ctl_s[N-1].neg2);
			end
		end
	end

	assign out_valid  = v_q;
	assign out_status = st_q;
	assign out_first  = first_q;
	assign out_second = second_q;

endmodule
